// ===== rtl/core/clne_pkg.sv =====
// Package for the character LCD nibble command encoder.
// Holds request codes, port bit masks, wait constants and the job type
// shared by the front, the job queue and the back. No dependencies.
package clne_pkg;

    localparam int unsigned REQ_W   = 4;
    localparam int unsigned WAIT_W  = 12;

    localparam logic [REQ_W-1:0] REQ_DATA      = 4'd0;
    localparam logic [REQ_W-1:0] REQ_COMMAND   = 4'd1;
    localparam logic [REQ_W-1:0] REQ_NIBBLE    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_CURSOR    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DISPLAY   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_ENTRY     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd6;
    localparam logic [REQ_W-1:0] REQ_HOME      = 4'd7;
    localparam logic [REQ_W-1:0] REQ_SCROLL_L  = 4'd8;
    localparam logic [REQ_W-1:0] REQ_SCROLL_R  = 4'd9;
    localparam logic [REQ_W-1:0] REQ_CGRAM     = 4'd10;
    localparam logic [REQ_W-1:0] REQ_FUNC_SET  = 4'd11;
    localparam logic [REQ_W-1:0] REQ_EXP_RESET = 4'd12;

    localparam logic [7:0] PORT_EN = 8'h04;
    localparam logic [7:0] PORT_BL = 8'h08;
    localparam logic [7:0] PORT_RS = 8'h01;

    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;
    localparam logic [7:0] CMD_DISPLAY   = 8'h08;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SCROLL_L  = 8'h18;
    localparam logic [7:0] CMD_SCROLL_R  = 8'h1C;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h20;
    localparam logic [7:0] FUNC_TWO_LINE = 8'h08;

    localparam logic [WAIT_W-1:0] WAIT_PLAIN = 12'd0;
    localparam logic [WAIT_W-1:0] WAIT_EN_HI = 12'd1;
    localparam logic [WAIT_W-1:0] WAIT_EN_LO = 12'd50;
    localparam logic [WAIT_W-1:0] WAIT_SLOW  = 12'd2050;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_NIBBLE,
        JOB_EXP_RESET,
        JOB_NONE
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] value;
        logic       rs;
        logic       bl;
        logic       slow;
    } t_job;

    localparam int unsigned JOB_W = $bits(t_job);

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/core/clne_front.sv =====
// Front of the encoder: classifies a request into a job for the back.
// Holds the line-mode register. Depends on clne_pkg.
module clne_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  logic                i_cfg_data,
    input  logic [3:0]          i_req_type,
    input  logic [7:0]          i_byte_value,
    input  logic [6:0]          i_column,
    input  logic [1:0]          i_row,
    input  logic                i_flag_on_or_left,
    input  logic                i_flag_cursor_or_increment,
    input  logic                i_flag_blink,
    input  logic [2:0]          i_cgram_slot,
    input  logic                i_backlight,
    output clne_pkg::t_job      o_job
);
    import clne_pkg::*;

    logic       r_two_line;
    logic [6:0] addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_line <= 1'b1;
        end else if (i_cfg_wr) begin
            r_two_line <= i_cfg_data;
        end
    end

    assign addr = i_column + row_base(i_row);

    always_comb begin
        o_job.kind  = JOB_BYTE;
        o_job.value = 8'h00;
        o_job.rs    = 1'b0;
        o_job.bl    = i_backlight;
        o_job.slow  = 1'b0;
        unique case (i_req_type)
            REQ_DATA: begin
                o_job.value = i_byte_value;
                o_job.rs    = 1'b1;
            end
            REQ_COMMAND: o_job.value = i_byte_value;
            REQ_NIBBLE: begin
                o_job.kind  = JOB_NIBBLE;
                o_job.value = i_byte_value;
            end
            REQ_CURSOR:  o_job.value = CMD_DDRAM | {1'b0, addr};
            REQ_DISPLAY: o_job.value = CMD_DISPLAY | {5'd0, i_flag_on_or_left,
                                           i_flag_cursor_or_increment, i_flag_blink};
            REQ_ENTRY:   o_job.value = CMD_ENTRY | {6'd0, i_flag_on_or_left,
                                           i_flag_cursor_or_increment};
            REQ_CLEAR: begin
                o_job.value = CMD_CLEAR;
                o_job.slow  = 1'b1;
            end
            REQ_HOME: begin
                o_job.value = CMD_HOME;
                o_job.slow  = 1'b1;
            end
            REQ_SCROLL_L: o_job.value = CMD_SCROLL_L;
            REQ_SCROLL_R: o_job.value = CMD_SCROLL_R;
            REQ_CGRAM:    o_job.value = CMD_CGRAM | {2'b00, i_cgram_slot, 3'b000};
            REQ_FUNC_SET: o_job.value = CMD_FUNC_SET | (r_two_line ? FUNC_TWO_LINE : 8'h00);
            REQ_EXP_RESET: o_job.kind = JOB_EXP_RESET;
            default:       o_job.kind = JOB_NONE;
        endcase
    end

endmodule

// ===== rtl/core/clne_fifo.sv =====
// Short job queue between the front and the back of the encoder.
// Storage is a small register array with one write and one read port. Depends on clne_pkg.
module clne_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clne_pkg::t_job i_job,
    input  logic           i_pop,
    output clne_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    import clne_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/clne_back.sv =====
// Back of the encoder: expands one queued job into port bytes, one per cycle.
// Each nibble goes out as plain, enable high and enable low. Depends on clne_pkg.
module clne_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  clne_pkg::t_job                 i_job,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic [7:0]                     o_port_byte,
    output logic [clne_pkg::WAIT_W-1:0]    o_wait_us,
    output logic                           o_last_byte
);
    import clne_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_EN_HI,
        PH_EN_LO
    } t_phase;

    logic       r_active;
    t_job       r_cur;
    logic       r_nib;
    t_phase     r_ph;

    logic [7:0]        base;
    logic [7:0]        n_port_byte;
    logic [WAIT_W-1:0] n_wait_us;
    logic              n_last;

    always_comb begin
        base = {(r_nib ? r_cur.value[3:0] : r_cur.value[7:4]), 4'h0}
             | (r_cur.bl ? PORT_BL : 8'h00) | (r_cur.rs ? PORT_RS : 8'h00);
        n_last = 1'b0;
        case (r_cur.kind)
            JOB_NIBBLE:    n_last = (r_ph == PH_EN_LO);
            JOB_EXP_RESET: n_last = 1'b1;
            default:       n_last = r_nib && (r_ph == PH_EN_LO);
        endcase
        n_port_byte = base;
        n_wait_us   = WAIT_PLAIN;
        if (r_cur.kind == JOB_EXP_RESET) begin
            n_port_byte = r_cur.bl ? PORT_BL : 8'h00;
        end else begin
            case (r_ph)
                PH_EN_HI: begin
                    n_port_byte = base | PORT_EN;
                    n_wait_us   = WAIT_EN_HI;
                end
                PH_EN_LO: n_wait_us = (n_last && r_cur.slow) ? WAIT_SLOW : WAIT_EN_LO;
                default:  n_wait_us = WAIT_PLAIN;
            endcase
        end
    end

    assign o_pop = !i_empty && (!r_active || n_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cur       <= '0;
            r_nib       <= 1'b0;
            r_ph        <= PH_PLAIN;
            o_strobe    <= 1'b0;
            o_port_byte <= 8'h00;
            o_wait_us   <= WAIT_PLAIN;
            o_last_byte <= 1'b0;
        end else begin
            o_strobe    <= r_active;
            o_port_byte <= n_port_byte;
            o_wait_us   <= n_wait_us;
            o_last_byte <= n_last;
            if (o_pop) begin
                r_cur    <= i_job;
                r_active <= 1'b1;
                r_nib    <= 1'b0;
                r_ph     <= PH_PLAIN;
            end else if (r_active && n_last) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                unique case (r_ph)
                    PH_PLAIN: r_ph <= PH_EN_HI;
                    PH_EN_HI: r_ph <= PH_EN_LO;
                    default: begin
                        r_ph  <= PH_PLAIN;
                        r_nib <= 1'b1;
                    end
                endcase
            end
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_ph == PH_PLAIN || r_ph == PH_EN_HI || r_ph == PH_EN_LO))
        else $error("phase counter out of range");

    a_enable_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_cur.kind != JOB_EXP_RESET && r_ph == PH_EN_HI) |=>
        (o_strobe && o_port_byte[2] && o_wait_us == WAIT_EN_HI))
        else $error("enable-high byte not emitted");

    a_slow_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_wait_us == WAIT_SLOW) |-> o_last_byte)
        else $error("long wait on a byte that is not last");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/char_lcd_nibble_command_encoder.sv =====
// Top level of the character LCD nibble command encoder.
// Ties the front, the job queue and the back together. Depends on clne_pkg.
//
// A request is taken when start is high and busy is low; busy rises only when
// the job queue is full. Each request becomes up to six port bytes, one per
// cycle on o_strobe, with o_last_byte on the final one; the receiver cannot
// stall them. A full byte request becomes six port bytes, a nibble three and
// an expander reset one; the back takes the next job with the last byte of
// the current one, so queued requests go out without gaps. The first byte
// passes the job queue and the back's job register before the registered
// output. Unused request types emit nothing. The line-mode register is
// written through the configuration channel, which is always ready.
module char_lcd_nibble_command_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  i_req_type,
    input  logic [7:0]                  i_byte_value,
    input  logic [6:0]                  i_column,
    input  logic [1:0]                  i_row,
    input  logic                        i_flag_on_or_left,
    input  logic                        i_flag_cursor_or_increment,
    input  logic                        i_flag_blink,
    input  logic [2:0]                  i_cgram_slot,
    input  logic                        i_backlight,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_strobe,
    output logic [7:0]                  o_port_byte,
    output logic [clne_pkg::WAIT_W-1:0] o_wait_us,
    output logic                        o_last_byte
);
    import clne_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;
    assign busy        = full;
    assign push        = start && !full && (front_job.kind != JOB_NONE);

    clne_front u_front (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_cfg_wr                   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data                 (i_cfg_data),
        .i_req_type                 (i_req_type),
        .i_byte_value               (i_byte_value),
        .i_column                   (i_column),
        .i_row                      (i_row),
        .i_flag_on_or_left          (i_flag_on_or_left),
        .i_flag_cursor_or_increment (i_flag_cursor_or_increment),
        .i_flag_blink               (i_flag_blink),
        .i_cgram_slot               (i_cgram_slot),
        .i_backlight                (i_backlight),
        .o_job                      (front_job)
    );

    clne_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    clne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_port_byte (o_port_byte),
        .o_wait_us   (o_wait_us),
        .o_last_byte (o_last_byte)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for char_lcd_nibble_command_encoder.
// Runs a table of directed requests, then random bursts under both line modes, and
// checks every port byte against an in-bench encoder. Depends on clne_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clne_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;

    localparam logic [3:0] REQ_SPARE_LO = 4'd13;
    localparam logic [3:0] REQ_SPARE_HI = 4'd15;

    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;
    localparam logic [7:0] BIT_RS = 8'h01;

    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
    localparam logic [7:0] LCD_DISPLAY   = 8'h08;
    localparam logic [7:0] LCD_ENTRY     = 8'h04;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [7:0] LCD_SHIFT_L   = 8'h18;
    localparam logic [7:0] LCD_SHIFT_R   = 8'h1C;
    localparam logic [7:0] LCD_FUNCTION  = 8'h20;
    localparam logic [7:0] LCD_TWO_LINES = 8'h08;

    localparam logic [WAIT_W-1:0] US_PLAIN  = 12'd0;
    localparam logic [WAIT_W-1:0] US_EN_HI  = 12'd1;
    localparam logic [WAIT_W-1:0] US_EN_LO  = 12'd50;
    localparam logic [WAIT_W-1:0] US_CLEAR  = 12'd2050;

    localparam logic [6:0] DDRAM_ROW_OFFSET [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    typedef struct packed {
        logic [3:0] rtype;
        logic [7:0] value;
        logic [6:0] column;
        logic [1:0] row;
        logic       on_or_left;
        logic       cursor_or_inc;
        logic       blink;
        logic [2:0] slot;
        logic       bl;
    } lcd_req_t;

    typedef enum logic [1:0] {
        GOLD_PREDICT,
        GOLD_CMD,
        GOLD_PORT,
        GOLD_SILENT
    } gold_e;

    typedef struct packed {
        lcd_req_t   req;
        gold_e      gold;
        logic [7:0] code;
    } script_row_t;

    typedef struct packed {
        logic [7:0]        port;
        logic [WAIT_W-1:0] settle_us;
        logic              is_last;
    } port_write_t;

    // Directed requests; the typed code is the command byte (or the single port byte).
    script_row_t script [25] = '{
        '{'{REQ_FUNC_SET,  8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'h28},
        '{'{REQ_EXP_RESET, 8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_PORT,    8'h08},
        '{'{REQ_EXP_RESET, 8'hFF, 7'd127, 2'd3, 1, 1, 1, 3'd7, 0}, GOLD_PORT,    8'h00},
        '{'{REQ_DATA,      8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_PREDICT, 8'h00},
        '{'{REQ_DATA,      8'hFF, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_PREDICT, 8'h00},
        '{'{REQ_COMMAND,   8'hA5, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'hA5},
        '{'{REQ_COMMAND,   8'h5A, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'h5A},
        '{'{REQ_NIBBLE,    8'hFF, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_PREDICT, 8'h00},
        '{'{REQ_NIBBLE,    8'h0F, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_PREDICT, 8'h00},
        '{'{REQ_CURSOR,    8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'h80},
        '{'{REQ_CURSOR,    8'h00, 7'd127, 2'd1, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'hBF},
        '{'{REQ_CURSOR,    8'h00, 7'h6B,  2'd2, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'hFF},
        '{'{REQ_CURSOR,    8'h00, 7'd127, 2'd3, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'hD3},
        '{'{REQ_DISPLAY,   8'h00, 7'd0,   2'd0, 1, 1, 1, 3'd0, 1}, GOLD_CMD,     8'h0F},
        '{'{REQ_DISPLAY,   8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'h08},
        '{'{REQ_ENTRY,     8'h00, 7'd0,   2'd0, 1, 1, 1, 3'd0, 1}, GOLD_CMD,     8'h07},
        '{'{REQ_ENTRY,     8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'h04},
        '{'{REQ_CLEAR,     8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_PREDICT, 8'h00},
        '{'{REQ_HOME,      8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_PREDICT, 8'h00},
        '{'{REQ_SCROLL_L,  8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 1}, GOLD_CMD,     8'h18},
        '{'{REQ_SCROLL_R,  8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'h1C},
        '{'{REQ_CGRAM,     8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd7, 1}, GOLD_CMD,     8'h78},
        '{'{REQ_CGRAM,     8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_CMD,     8'h40},
        '{'{REQ_SPARE_LO,  8'hFF, 7'd127, 2'd3, 1, 1, 1, 3'd7, 1}, GOLD_SILENT,  8'h00},
        '{'{REQ_SPARE_HI,  8'h00, 7'd0,   2'd0, 0, 0, 0, 3'd0, 0}, GOLD_SILENT,  8'h00}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    lcd_req_t    req_drv = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        o_cfg_ready;
    logic        o_strobe;
    logic [7:0]  o_port_byte;
    logic [WAIT_W-1:0] o_wait_us;
    logic        o_last_byte;

    port_write_t port_writes [$];
    logic        two_line = 1'b1;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    always #10 i_clk = ~i_clk;

    char_lcd_nibble_command_encoder DUT (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .start                      (start),
        .busy                       (busy),
        .i_req_type                 (req_drv.rtype),
        .i_byte_value               (req_drv.value),
        .i_column                   (req_drv.column),
        .i_row                      (req_drv.row),
        .i_flag_on_or_left          (req_drv.on_or_left),
        .i_flag_cursor_or_increment (req_drv.cursor_or_inc),
        .i_flag_blink               (req_drv.blink),
        .i_cgram_slot               (req_drv.slot),
        .i_backlight                (req_drv.bl),
        .i_cfg_valid                (i_cfg_valid),
        .o_cfg_ready                (o_cfg_ready),
        .i_cfg_data                 (i_cfg_data),
        .o_strobe                   (o_strobe),
        .o_port_byte                (o_port_byte),
        .o_wait_us                  (o_wait_us),
        .o_last_byte                (o_last_byte)
    );

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatches++;
        $display("[%0t] mismatch on %s: expected 0x%h, got 0x%h", $time, what, want, got);
    endtask

    function automatic void queue_port(input logic [7:0] pb, input logic [WAIT_W-1:0] us,
                                       input logic fin);
        port_writes.push_back('{pb, us, fin});
    endfunction

    // One nibble is strobed into the panel as plain, enable high, enable low.
    function automatic void queue_nibble(input logic [7:0] v, input logic slow,
                                         input logic fin);
        queue_port(v, US_PLAIN, 1'b0);
        queue_port(v | BIT_EN, US_EN_HI, 1'b0);
        queue_port(v & ~BIT_EN, slow ? US_CLEAR : US_EN_LO, fin);
    endfunction

    function automatic void queue_lcd_byte(input logic [7:0] val, input logic [7:0] rs,
                                           input logic [7:0] bl, input logic slow);
        queue_nibble({val[7:4], 4'h0} | rs | bl, 1'b0, 1'b0);
        queue_nibble({val[3:0], 4'h0} | rs | bl, slow, 1'b1);
    endfunction

    function automatic void encode_request(input lcd_req_t r);
        logic [7:0] bl;
        logic [6:0] addr;
        bl = r.bl ? BIT_BL : 8'h00;
        addr = r.column + DDRAM_ROW_OFFSET[r.row];
        case (r.rtype)
            REQ_DATA:      queue_lcd_byte(r.value, BIT_RS, bl, 1'b0);
            REQ_COMMAND:   queue_lcd_byte(r.value, 8'h00, bl, 1'b0);
            REQ_NIBBLE:    queue_nibble({r.value[7:4], 4'h0} | bl, 1'b0, 1'b1);
            REQ_CURSOR:    queue_lcd_byte(LCD_SET_DDRAM | {1'b0, addr}, 8'h00, bl, 1'b0);
            REQ_DISPLAY:   queue_lcd_byte(LCD_DISPLAY | {5'b0, r.on_or_left, r.cursor_or_inc,
                                          r.blink}, 8'h00, bl, 1'b0);
            REQ_ENTRY:     queue_lcd_byte(LCD_ENTRY | {6'b0, r.on_or_left, r.cursor_or_inc},
                                          8'h00, bl, 1'b0);
            REQ_CLEAR:     queue_lcd_byte(LCD_CLEAR, 8'h00, bl, 1'b1);
            REQ_HOME:      queue_lcd_byte(LCD_HOME, 8'h00, bl, 1'b1);
            REQ_SCROLL_L:  queue_lcd_byte(LCD_SHIFT_L, 8'h00, bl, 1'b0);
            REQ_SCROLL_R:  queue_lcd_byte(LCD_SHIFT_R, 8'h00, bl, 1'b0);
            REQ_CGRAM:     queue_lcd_byte(LCD_SET_CGRAM | {2'b0, r.slot, 3'b0}, 8'h00, bl, 1'b0);
            REQ_FUNC_SET:  queue_lcd_byte(LCD_FUNCTION | (two_line ? LCD_TWO_LINES : 8'h00),
                                          8'h00, bl, 1'b0);
            REQ_EXP_RESET: queue_port(bl, US_PLAIN, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t r;
        r.rtype = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI))
                                               : 4'($urandom_range(REQ_DATA, REQ_EXP_RESET));
        r.value = 8'($urandom_range(0, 255));
        r.column = 7'($urandom_range(0, 127));
        r.row = 2'($urandom_range(0, 3));
        r.on_or_left = 1'($urandom_range(0, 1));
        r.cursor_or_inc = 1'($urandom_range(0, 1));
        r.blink = 1'($urandom_range(0, 1));
        r.slot = 3'($urandom_range(0, 7));
        r.bl = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic issue(input lcd_req_t r, input gold_e gold, input logic [7:0] code);
        start <= 1'b1;
        req_drv <= r;
        do @(posedge i_clk); while (busy);
        case (gold)
            GOLD_CMD:    queue_lcd_byte(code, 8'h00, r.bl ? BIT_BL : 8'h00, 1'b0);
            GOLD_PORT:   queue_port(code, US_PLAIN, 1'b1);
            GOLD_SILENT: ;
            default:     encode_request(r);
        endcase
    endtask

    task automatic pause(input int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (port_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        two_line = mode;
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        lcd_req_t r;
        sent = 0;
        while (sent < n_items) begin
            burst = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            repeat (burst) begin
                r = random_request();
                issue(r, GOLD_PREDICT, 8'h00);
                if (r.rtype <= REQ_EXP_RESET) sent++;
            end
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
        end
    endtask

    always @(posedge i_clk) begin : port_monitor
        port_write_t want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (port_writes.size() == 0) begin
                report_mismatch("unexpected port byte", 16'h0, {8'h0, o_port_byte});
            end else begin
                want = port_writes.pop_front();
                if (o_port_byte !== want.port)
                    report_mismatch("port_byte", {8'h0, want.port}, {8'h0, o_port_byte});
                if (o_wait_us !== want.settle_us)
                    report_mismatch("wait_us", {4'h0, want.settle_us}, {4'h0, o_wait_us});
                if (o_last_byte !== want.is_last)
                    report_mismatch("last_byte", {15'h0, want.is_last}, {15'h0, o_last_byte});
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (script[i]) begin
            issue(script[i].req, script[i].gold, script[i].code);
            if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
        end
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_line_mode(phase % 2 == 1);
            run_random(125);
        end
        drain();
        if (mismatches == 0 && port_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== char_lcd_nibble_command_encoder.f =====
rtl/core/clne_pkg.sv
rtl/core/clne_front.sv
rtl/core/clne_fifo.sv
rtl/core/clne_back.sv
rtl/core/char_lcd_nibble_command_encoder.sv
tb/sv/tb_top.sv
